// ----- rtl/rvc_pkg.sv -----
package rvc_pkg;

    localparam int SET_DEPTH   = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int MAX_REPORTS = 8;

    localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W = $clog2(SET_DEPTH + 1);
    localparam int OCC_W = CNT_W;
    localparam int REP_W = $clog2(MAX_REPORTS + 1);

endpackage

// ----- rtl/rvc_in_if.sv -----
interface rvc_in_if import rvc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   set_end;

    modport source (output valid, output value, output set_end, input ready);
    modport sink   (input valid, input value, input set_end, output ready);
endinterface

// ----- rtl/rvc_out_if.sv -----
interface rvc_out_if import rvc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] repeated_value;
    logic [OCC_W-1:0]       occurrences;
    logic                   final_report;
    logic                   dropped;

    modport source (output valid, output repeated_value, output occurrences,
                    output final_report, output dropped, input ready);
    modport sink   (input valid, input repeated_value, input occurrences,
                    input final_report, input dropped, output ready);
endinterface

// ----- rtl/repeat_value_counter_unit.sv -----
// Loading: one transaction per cycle while idle, values written to the store RAM in arrival order.
// Scan after the last item of a set of N stored values, per candidate: one RAM read for the
// candidate, one read per compared entry, one decision step; a final report closes the set,
// and the scan waits when the report output stalls.
// No input is taken during the scan; the store has a single read port, read one entry at a time.
// Synchronous active-low reset clears fill count, overflow flag and control; store undefined.
module repeat_value_counter_unit import rvc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvc_in_if.sink    i_in,
    rvc_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_RDJ0 = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic                   r_ovf, n_ovf;
    logic [CNT_W-1:0]       r_n, n_n;
    logic                   r_drop, n_drop;
    logic [IDX_W-1:0]       r_i, n_i;
    logic [IDX_W-1:0]       r_j, n_j;
    logic [VALUE_WIDTH-1:0] r_cand, n_cand;
    logic                   r_seen, n_seen;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [REP_W-1:0]       r_nrep, n_nrep;
    logic                   r_has_pend, n_has_pend;
    logic [VALUE_WIDTH-1:0] r_pend_val, n_pend_val;
    logic [CNT_W-1:0]       r_pend_cnt, n_pend_cnt;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_val;
    logic [OCC_W-1:0]       r_out_cnt;
    logic                   r_out_final;
    logic                   r_out_drop;

    logic                   out_load;
    logic [VALUE_WIDTH-1:0] out_val;
    logic [CNT_W-1:0]       out_cnt;
    logic                   out_final;

    logic                   in_acc;
    logic                   slot_free;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   eq;
    logic                   last_j;
    logic                   last_i;
    logic                   new_rep;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign ram_we     = in_acc && (r_fill < CNT_W'(SET_DEPTH));

    assign eq      = (ram_rdata == r_cand);
    assign last_j  = ({1'b0, r_j} == CNT_W'(r_n - 1'b1));
    assign last_i  = ({1'b0, r_i} == CNT_W'(r_n - 1'b1));
    assign new_rep = !r_seen && (r_cnt > CNT_W'(1));

    rvc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SET_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_ovf      = r_ovf;
        n_n        = r_n;
        n_drop     = r_drop;
        n_i        = r_i;
        n_j        = r_j;
        n_cand     = r_cand;
        n_seen     = r_seen;
        n_cnt      = r_cnt;
        n_nrep     = r_nrep;
        n_has_pend = r_has_pend;
        n_pend_val = r_pend_val;
        n_pend_cnt = r_pend_cnt;
        out_load   = 1'b0;
        out_val    = r_pend_val;
        out_cnt    = r_pend_cnt;
        out_final  = 1'b0;
        ram_raddr  = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (ram_we) begin
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.set_end) begin
                        n_n        = ram_we ? CNT_W'(r_fill + 1'b1) : r_fill;
                        n_drop     = r_ovf || !ram_we;
                        n_fill     = '0;
                        n_ovf      = 1'b0;
                        n_i        = '0;
                        n_nrep     = '0;
                        n_has_pend = 1'b0;
                        n_state    = S_RDI;
                    end
                end
            end
            S_RDI: begin
                ram_raddr = r_i;
                n_state   = S_RDJ0;
            end
            S_RDJ0: begin
                n_cand    = ram_rdata;
                ram_raddr = '0;
                n_j       = '0;
                n_seen    = 1'b0;
                n_cnt     = '0;
                n_state   = S_CMP;
            end
            S_CMP: begin
                ram_raddr = IDX_W'(r_j + 1'b1);
                if (eq && (r_j < r_i)) begin
                    n_seen = 1'b1;
                end
                if (eq && (r_j >= r_i)) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (last_j) begin
                    n_state = S_DEC;
                end else begin
                    n_j = IDX_W'(r_j + 1'b1);
                end
            end
            S_DEC: begin
                if (!(new_rep && r_has_pend && !slot_free)) begin
                    if (new_rep) begin
                        out_load   = r_has_pend;
                        n_pend_val = r_cand;
                        n_pend_cnt = r_cnt;
                        n_has_pend = 1'b1;
                        n_nrep     = r_nrep + 1'b1;
                    end
                    if ((new_rep && (r_nrep == REP_W'(MAX_REPORTS - 1))) || last_i) begin
                        n_state = S_FIN;
                    end else begin
                        n_i     = IDX_W'(r_i + 1'b1);
                        n_state = S_RDI;
                    end
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    out_final = 1'b1;
                    out_val   = r_has_pend ? r_pend_val : '0;
                    out_cnt   = r_has_pend ? r_pend_cnt : '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_nrep      <= '0;
            r_has_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_ovf      <= n_ovf;
            r_nrep     <= n_nrep;
            r_has_pend <= n_has_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_drop     <= n_drop;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cand     <= n_cand;
        r_seen     <= n_seen;
        r_cnt      <= n_cnt;
        r_pend_val <= n_pend_val;
        r_pend_cnt <= n_pend_cnt;
        if (out_load) begin
            r_out_val   <= out_val;
            r_out_cnt   <= OCC_W'(out_cnt);
            r_out_final <= out_final;
            r_out_drop  <= r_drop;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.repeated_value = r_out_val;
    assign o_out.occurrences    = r_out_cnt;
    assign o_out.final_report   = r_out_final;
    assign o_out.dropped        = r_out_drop;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(SET_DEPTH))
        else $error("fill count beyond store depth");

    a_set_end_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.set_end) |=> (r_state == S_RDI && r_fill == '0 && !r_ovf))
        else $error("set end did not start the scan");

    a_report_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_nrep <= REP_W'(MAX_REPORTS)))
        else $error("too many reports");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> (r_cnt <= r_n && r_cnt != '0))
        else $error("occurrence count out of range");

    a_final_closes_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && slot_free) |=>
            (r_state == S_IDLE && r_out_valid && r_out_final))
        else $error("final report not issued");
`endif

endmodule

// ----- rtl/rvc_ram.sv -----
module rvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/rvc_checker.sv -----
`timescale 1ns / 1ps

module rvc_checker import rvc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_in_value,
    input  logic                   i_in_set_end,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [VALUE_WIDTH-1:0] i_out_value,
    input  logic [OCC_W-1:0]       i_out_occurrences,
    input  logic                   i_out_final,
    input  logic                   i_out_dropped,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_reports_seen
);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [OCC_W-1:0]       occ;
        logic                   last;
        logic                   dropped;
    } t_dup_report;

    t_dup_report            expected_reports[$];
    logic [VALUE_WIDTH-1:0] set_vals [SET_DEPTH];
    int                     set_fill;
    bit                     set_overflow;
    int                     fails;
    int                     seen;

    initial begin
        fails          = 0;
        seen           = 0;
        set_fill       = 0;
        set_overflow   = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        o_reports_seen = 0;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on report %0d: %s got 0x%0h, expected 0x%0h",
                 $time, seen, field, got, want);
        fails++;
    endtask

    // Scan the finished set: each value that repeats, in order of first appearance.
    task automatic tally_repeats();
        t_dup_report reps [MAX_REPORTS];
        t_dup_report rep;
        int          i;
        int          j;
        int          n;
        int          count;
        bit          earlier;
        n = 0;
        for (i = 0; i < set_fill && n < MAX_REPORTS; i++) begin
            earlier = 0;
            for (j = 0; j < i; j++) begin
                if (set_vals[j] == set_vals[i]) begin
                    earlier = 1;
                end
            end
            if (!earlier) begin
                count = 1;
                for (j = i + 1; j < set_fill; j++) begin
                    if (set_vals[j] == set_vals[i]) begin
                        count++;
                    end
                end
                if (count > 1) begin
                    rep.value   = set_vals[i];
                    rep.occ     = OCC_W'(count);
                    rep.last    = 1'b0;
                    rep.dropped = set_overflow;
                    reps[n]     = rep;
                    n++;
                end
            end
        end
        if (n == 0) begin
            rep         = '0;
            rep.last    = 1'b1;
            rep.dropped = set_overflow;
            expected_reports.push_back(rep);
        end else begin
            reps[n-1].last = 1'b1;
            for (i = 0; i < n; i++) begin
                expected_reports.push_back(reps[i]);
            end
        end
        set_fill     = 0;
        set_overflow = 0;
    endtask

    task automatic take_value();
        if (set_fill < SET_DEPTH) begin
            set_vals[set_fill] = i_in_value;
            set_fill++;
        end else begin
            set_overflow = 1;
        end
        if (i_in_set_end) begin
            tally_repeats();
        end
    endtask

    task automatic check_report();
        t_dup_report want;
        if (expected_reports.size() == 0) begin
            $display("[%0t] unexpected report: value 0x%0h occurrences %0d",
                     $time, i_out_value, i_out_occurrences);
            fails++;
        end else begin
            want = expected_reports.pop_front();
            if (i_out_value !== want.value) begin
                report_mismatch("repeated_value", int'(i_out_value), int'(want.value));
            end
            if (i_out_occurrences !== want.occ) begin
                report_mismatch("occurrences", int'(i_out_occurrences), int'(want.occ));
            end
            if (i_out_final !== want.last) begin
                report_mismatch("final_report", int'(i_out_final), int'(want.last));
            end
            if (i_out_dropped !== want.dropped) begin
                report_mismatch("dropped", int'(i_out_dropped), int'(want.dropped));
            end
        end
        seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_fill     = 0;
            set_overflow = 0;
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_report();
            end
            if (i_in_valid && i_in_ready) begin
                take_value();
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_reports.size();
        o_reports_seen <= seen;
    end

endmodule

// ----- tb/tb_repeat_value_counter_unit.sv -----
`timescale 1ns / 1ps

module tb_repeat_value_counter_unit;
    import rvc_pkg::*;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    localparam int ITEM_TARGET  = 380;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = SET_DEPTH * (SET_DEPTH + 3) + 16;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   burst_left = 0;
    int   items_sent = 0;
    int   sets_sent = 0;
    int   overflow_sets = 0;
    int   fail_count;
    int   pending;
    int   reports_seen;
    int   stall_mode = 0;
    int   stall_tick = 0;

    rvc_in_if  in_ch ();
    rvc_out_if out_ch ();

    repeat_value_counter_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rvc_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_value        (in_ch.value),
        .i_in_set_end      (in_ch.set_end),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_value       (out_ch.repeated_value),
        .i_out_occurrences (out_ch.occurrences),
        .i_out_final       (out_ch.final_report),
        .i_out_dropped     (out_ch.dropped),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_reports_seen    (reports_seen)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern, mode changes periodically
    always @(posedge clk) begin
        stall_tick++;
        if (stall_tick % 97 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                out_ch.ready <= ((stall_tick % 8) < 5);
            end
        endcase
    end

    task automatic send_value(input t_value v, input logic last);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.set_end <= last;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_set(input t_value vals[$]);
        int k;
        for (k = 0; k < vals.size(); k++) begin
            send_value(vals[k], k == vals.size() - 1);
        end
        sets_sent++;
        if (vals.size() > SET_DEPTH) begin
            overflow_sets++;
        end
    endtask

    initial begin
        t_value set_q[$];
        t_value pool [SET_DEPTH];
        int     len;
        int     pool_n;
        int     shape;
        int     k;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.set_end = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single item, nothing repeats
        set_q = '{16'h0000};
        send_set(set_q);
        // all-ones value filling the store, last item dropped
        set_q.delete();
        for (k = 0; k <= SET_DEPTH; k++) begin
            set_q.push_back(16'hFFFF);
        end
        send_set(set_q);
        // two repeated values at both extremes
        set_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        send_set(set_q);

        while (items_sent < ITEM_TARGET) begin
            set_q.delete();
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                // overflow
                len = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 6);
            end else if (shape <= 2) begin
                len = SET_DEPTH;
            end else begin
                len = $urandom_range(1, SET_DEPTH);
            end
            if (shape == 1) begin
                // eight distinct values, each twice: most reports per set
                for (k = 0; k < SET_DEPTH / 2; k++) begin
                    pool[k] = (t_value'($urandom) & 16'hFFF0) | t_value'(k);
                    set_q.push_back(pool[k]);
                end
                for (k = SET_DEPTH / 2 - 1; k >= 0; k--) begin
                    set_q.push_back(pool[k]);
                end
            end else if (shape == 9) begin
                for (k = 0; k < len; k++) begin
                    set_q.push_back(t_value'($urandom));
                end
            end else begin
                pool_n = $urandom_range(1, (len < SET_DEPTH) ? len : SET_DEPTH);
                for (k = 0; k < pool_n; k++) begin
                    pool[k] = t_value'($urandom);
                end
                for (k = 0; k < len; k++) begin
                    set_q.push_back(pool[$urandom_range(0, pool_n - 1)]);
                end
            end
            send_set(set_q);
        end

        in_ch.valid   <= 1'b0;
        in_ch.set_end <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d values in %0d sets (%0d overflowing the store)",
                 items_sent, sets_sent, overflow_sets);
        $display("checked %0d repeat reports, %0d mismatches", reports_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
